FILE: design/mpd_pkg.sv
// shared constants, codes and the pair flow type for the minimum pairwise distance unit
package mpd_pkg;

    localparam int MAX_POINTS = 256;
    localparam int MAX_DIMS   = 16;
    localparam int COORD_BITS = 12;

    localparam int PT_IDX_W  = $clog2(MAX_POINTS);
    localparam int PT_CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIM_IDX_W = $clog2(MAX_DIMS);
    localparam int DIM_CNT_W = $clog2(MAX_DIMS + 1);

    localparam int NP_REG_W  = 9;
    localparam int ND_REG_W  = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 9;

    localparam int L1_W = 16;
    localparam int L2_W = 28;
    localparam int SQ_W = 2 * COORD_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = CFG_IDX_W'(1);

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [PT_IDX_W-1:0] pi;
        logic [PT_IDX_W-1:0] pj;
        logic [L1_W-1:0]     s1;
        logic [L2_W-1:0]     s2;
    } flow_t;

endpackage

FILE: design/mpd_cell.sv
// one dimension cell: holds one coordinate column and adds its share to each pair's sums
module mpd_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            active,
    input  logic                            wr_en,
    input  logic [mpd_pkg::PT_IDX_W-1:0]    wr_addr,
    input  logic [mpd_pkg::COORD_BITS-1:0]  wr_data,
    input  mpd_pkg::flow_t                  flow_in,
    output mpd_pkg::flow_t                  flow_out
);
    import mpd_pkg::*;

    logic [COORD_BITS-1:0] mem [0:MAX_POINTS-1];
    logic [COORD_BITS-1:0] rd_a_reg;
    logic [COORD_BITS-1:0] rd_b_reg;
    flow_t                 stage_reg;
    flow_t                 flow_reg;
    flow_t                 flow_next;
    logic [COORD_BITS-1:0] diff;
    logic [SQ_W-1:0]       sq;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[flow_in.pi];
        rd_b_reg <= mem[flow_in.pj];
    end

    always_comb
    begin
        diff = (rd_a_reg > rd_b_reg) ? (rd_a_reg - rd_b_reg) : (rd_b_reg - rd_a_reg);
        sq   = SQ_W'(diff) * SQ_W'(diff);
        flow_next = stage_reg;
        if (active)
        begin
            flow_next.s1 = stage_reg.s1 + L1_W'(diff);
            flow_next.s2 = stage_reg.s2 + L2_W'(sq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            flow_reg  <= '0;
        end
        else
        begin
            stage_reg <= flow_in;
            flow_reg  <= flow_next;
        end
    end

    assign flow_out = flow_reg;

endmodule

FILE: design/mpd_pair_gen.sv
// pair sequencer: issues every unordered point pair once, one per cycle
module mpd_pair_gen (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mpd_pkg::PT_IDX_W-1:0]  np_m1,
    output mpd_pkg::flow_t                head
);
    import mpd_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic [PT_IDX_W-1:0] i_reg;
    logic [PT_IDX_W-1:0] i_next;
    logic [PT_IDX_W-1:0] j_reg;
    logic [PT_IDX_W-1:0] j_next;
    logic                row_end;
    logic                last_pair;

    always_comb
    begin
        row_end   = (j_reg == np_m1);
        last_pair = row_end && (i_reg == np_m1 - PT_IDX_W'(1));
        busy_next = busy_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            j_next    = PT_IDX_W'(1);
        end
        else if (busy_reg)
        begin
            if (last_pair)
            begin
                busy_next = 1'b0;
            end
            if (row_end)
            begin
                i_next = i_reg + PT_IDX_W'(1);
                j_next = i_reg + PT_IDX_W'(2);
            end
            else
            begin
                j_next = j_reg + PT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
        end
    end

    always_comb
    begin
        head.valid = busy_reg;
        head.last  = busy_reg && last_pair;
        head.pi    = i_reg;
        head.pj    = j_reg;
        head.s1    = '0;
        head.s2    = '0;
    end

endmodule

FILE: design/min_pairwise_distance_unit.sv
// top level: point loader, pair sequencer, chain of dimension cells and minimum tracking
// throughput: one pair per cycle through the dimension cells; a single point gives its zero result
// in the cycle after its last coordinate is accepted
// input is held off while pairs are walked; a set's last item waits while a result is pending
// reset: async active low; 2 points of 1 dimension, loader empty, point store contents undefined
module min_pairwise_distance_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mpd_pkg::COORD_BITS-1:0]  coord,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mpd_pkg::L1_W-1:0]        min_l1,
    output logic [mpd_pkg::L2_W-1:0]        min_l2_squared,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpd_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import mpd_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [NP_REG_W-1:0]  num_points_reg;
    logic [ND_REG_W-1:0]  num_dims_reg;
    logic [PT_IDX_W-1:0]  pt_reg;
    logic [PT_IDX_W-1:0]  pt_next;
    logic [DIM_IDX_W-1:0] dim_reg;
    logic [DIM_IDX_W-1:0] dim_next;
    logic [L1_W-1:0]      best_l1_reg;
    logic [L1_W-1:0]      best_l1_next;
    logic [L2_W-1:0]      best_l2_reg;
    logic [L2_W-1:0]      best_l2_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [L1_W-1:0]      min_l1_reg;
    logic [L1_W-1:0]      min_l1_next;
    logic [L2_W-1:0]      min_l2_reg;
    logic [L2_W-1:0]      min_l2_next;

    logic [PT_CNT_W-1:0]  np_eff;
    logic [DIM_CNT_W-1:0] nd_eff;
    logic [PT_IDX_W-1:0]  np_m1;
    logic [DIM_IDX_W-1:0] nd_m1;
    logic                 last_dim;
    logic                 last_pt;
    logic                 set_last;
    logic                 in_acc;
    logic                 set_done;
    logic                 cfg_wr;
    logic                 cfg_hit;
    logic                 walk_start;
    logic [L1_W-1:0]      l1_min;
    logic [L2_W-1:0]      l2_min;
    logic [MAX_DIMS-1:0]  cell_act;
    logic [MAX_DIMS-1:0]  cell_wr;
    flow_t                head;
    flow_t                tail;
    flow_t                chain [0:MAX_DIMS];

    // register values out of range saturate
    always_comb
    begin
        if (num_points_reg == '0)
        begin
            np_eff = PT_CNT_W'(1);
        end
        else if (PT_CNT_W'(num_points_reg) > PT_CNT_W'(MAX_POINTS))
        begin
            np_eff = PT_CNT_W'(MAX_POINTS);
        end
        else
        begin
            np_eff = PT_CNT_W'(num_points_reg);
        end
        if (num_dims_reg == '0)
        begin
            nd_eff = DIM_CNT_W'(1);
        end
        else if (DIM_CNT_W'(num_dims_reg) > DIM_CNT_W'(MAX_DIMS))
        begin
            nd_eff = DIM_CNT_W'(MAX_DIMS);
        end
        else
        begin
            nd_eff = DIM_CNT_W'(num_dims_reg);
        end
    end

    assign np_m1 = PT_IDX_W'(np_eff - PT_CNT_W'(1));
    assign nd_m1 = DIM_IDX_W'(nd_eff - DIM_CNT_W'(1));

    assign last_dim   = (dim_reg == nd_m1);
    assign last_pt    = (pt_reg == np_m1);
    assign set_last   = last_dim && last_pt;
    assign in_stall   = (state_reg == ST_WALK) || (out_valid_reg && set_last);
    assign in_acc     = in_valid && !in_stall;
    assign set_done   = in_acc && set_last;
    assign walk_start = set_done && (np_eff != PT_CNT_W'(1));

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == REG_NUM_POINTS) || (cfg_index == REG_NUM_DIMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NP_REG_W'(2);
            num_dims_reg   <= ND_REG_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_NUM_POINTS: num_points_reg <= cfg_data[NP_REG_W-1:0];
                REG_NUM_DIMS:   num_dims_reg   <= cfg_data[ND_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    // loader counters, a write to either count register restarts the set
    always_comb
    begin
        pt_next  = pt_reg;
        dim_next = dim_reg;
        if (cfg_hit)
        begin
            pt_next  = '0;
            dim_next = '0;
        end
        else if (in_acc)
        begin
            if (last_dim)
            begin
                dim_next = '0;
                pt_next  = last_pt ? '0 : pt_reg + PT_IDX_W'(1);
            end
            else
            begin
                dim_next = dim_reg + DIM_IDX_W'(1);
            end
        end
    end

    mpd_pair_gen u_pair_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .np_m1 (np_m1),
        .head  (head)
    );

    assign chain[0] = head;

    genvar d;
    generate
        for (d = 0; d < MAX_DIMS; d++)
        begin : g_cell
            assign cell_act[d] = (DIM_CNT_W'(d) < nd_eff);
            assign cell_wr[d]  = in_acc && (dim_reg == DIM_IDX_W'(d));

            mpd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (cell_act[d]),
                .wr_en    (cell_wr[d]),
                .wr_addr  (pt_reg),
                .wr_data  (coord),
                .flow_in  (chain[d]),
                .flow_out (chain[d+1])
            );
        end
    endgenerate

    assign tail = chain[MAX_DIMS];

    always_comb
    begin
        l1_min = (tail.s1 < best_l1_reg) ? tail.s1 : best_l1_reg;
        l2_min = (tail.s2 < best_l2_reg) ? tail.s2 : best_l2_reg;

        state_next     = state_reg;
        best_l1_next   = best_l1_reg;
        best_l2_next   = best_l2_reg;
        out_valid_next = out_valid_reg && out_stall;
        min_l1_next    = min_l1_reg;
        min_l2_next    = min_l2_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (walk_start)
                begin
                    state_next   = ST_WALK;
                    best_l1_next = '1;
                    best_l2_next = '1;
                end
                else if (set_done)
                begin
                    // single point
                    out_valid_next = 1'b1;
                    min_l1_next    = '0;
                    min_l2_next    = '0;
                end
            end
            ST_WALK:
            begin
                if (tail.valid)
                begin
                    best_l1_next = l1_min;
                    best_l2_next = l2_min;
                    if (tail.last)
                    begin
                        state_next     = ST_LOAD;
                        out_valid_next = 1'b1;
                        min_l1_next    = l1_min;
                        min_l2_next    = l2_min;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pt_reg        <= '0;
            dim_reg       <= '0;
            best_l1_reg   <= '1;
            best_l2_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pt_reg        <= pt_next;
            dim_reg       <= dim_next;
            best_l1_reg   <= best_l1_next;
            best_l2_reg   <= best_l2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_l1_reg <= min_l1_next;
        min_l2_reg <= min_l2_next;
    end

    assign out_valid      = out_valid_reg;
    assign min_l1         = min_l1_reg;
    assign min_l2_squared = min_l2_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> state_reg == ST_WALK)
        else $error("pair issued outside walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == ST_WALK)
        else $error("pair sums left the chain outside walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(tail.valid && tail.last) || $past(set_done))
        else $error("result appeared without a finished set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dim_reg <= nd_m1) && (pt_reg <= np_m1))
        else $error("loader counters out of range");
`endif

endmodule
